// ===== hw/rtl/eotm_pkg.sv =====
// Package with the constants and the sine table function of the offset transform matrix core.
package eotm_pkg;

  // One turn and one quarter turn of the half angle, in 1/128 degree.
  localparam int TURN    = 46080;
  localparam int QUARTER = 11520;

  // Reciprocal of 45, scaled by 2^24 and rounded up (11520 = 256 * 45).
  localparam int RECIP45_SHIFT = 24;
  localparam logic [18:0] RECIP45 = 19'd372828;

  // Pi over two in Q2.30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Widths of the datapath words.
  localparam int TRIG_W = 16;  // Q1.15 sine and cosine
  localparam int PAIR_W = 32;  // product of two Q1.15 values
  localparam int QUAT_W = 34;  // quaternion and pair products in Q30
  localparam int ROT_W  = 33;  // clamped rotation entry in Q30
  localparam int FIELD_W = 32; // Q16.16 fields

  // Rounded Q1.15 sine of (90 degrees * k / depth), from a Q2.30 Taylor series.
  function automatic logic [14:0] sine_entry(input int k, input int depth);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x = (HALF_PI_Q30 * 64'(k) + 64'(depth / 2)) / 64'(depth);
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum = $signed(x);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) v = 64'sd32767;
    if (v < 64'sd0) v = 64'sd0;
    return v[14:0];
  endfunction

endpackage

// ===== hw/rtl/euler_offset_transform_matrix_core.sv =====
// Top level: Euler angles, scale and position to a 4x3 offset transform matrix.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_stall  | angle_x..z (16b), pos_x..z, scale_x..z (32b)
//  output  | out_valid / out_stall| m00..m22, m30..m32 (32b, Q16.16)
//
// Nine register stages: three for the table lookup, then pair products, quaternion,
// quaternion products, rotation entries, scale products, and round with saturation.
// A transaction is accepted every cycle unless a finished result is held by out_stall.
// Reset clears only the stage valid bits. A stalled output holds the whole pipeline.
module euler_offset_transform_matrix_core import eotm_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] angle_x,
  input  logic signed [15:0] angle_y,
  input  logic signed [15:0] angle_z,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] m00,
  output logic signed [31:0] m01,
  output logic signed [31:0] m02,
  output logic signed [31:0] m10,
  output logic signed [31:0] m11,
  output logic signed [31:0] m12,
  output logic signed [31:0] m20,
  output logic signed [31:0] m21,
  output logic signed [31:0] m22,
  output logic signed [31:0] m30,
  output logic signed [31:0] m31,
  output logic signed [31:0] m32
);

  localparam int STAGES = 9;

  // Global advance: everything moves unless a finished result is held.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Valid bits travel with the data.
  logic [STAGES-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end
  assign out_valid = vld[STAGES-1];

  // Position and scale ride along; scale is needed at the eighth stage.
  logic signed [FIELD_W-1:0] pos_d   [STAGES][3];
  logic signed [FIELD_W-1:0] scale_d [STAGES-2][3];
  always_ff @(posedge clk) begin
    if (en) begin
      pos_d[0][0] <= pos_x;
      pos_d[0][1] <= pos_y;
      pos_d[0][2] <= pos_z;
      scale_d[0][0] <= scale_x;
      scale_d[0][1] <= scale_y;
      scale_d[0][2] <= scale_z;
      for (int s = 1; s < STAGES; s++) begin
        pos_d[s] <= pos_d[s-1];
      end
      for (int s = 1; s < STAGES - 2; s++) begin
        scale_d[s] <= scale_d[s-1];
      end
    end
  end

  // Stages 1 to 3: sine and cosine of each half angle.
  logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz;
  eotm_wave #(.DEPTH(SINE_TABLE_DEPTH)) u_sx (
    .clk(clk), .en(en), .angle(angle_x), .cos_sel(1'b0), .wave(sx));
  eotm_wave #(.DEPTH(SINE_TABLE_DEPTH)) u_cx (
    .clk(clk), .en(en), .angle(angle_x), .cos_sel(1'b1), .wave(cx));
  eotm_wave #(.DEPTH(SINE_TABLE_DEPTH)) u_sy (
    .clk(clk), .en(en), .angle(angle_y), .cos_sel(1'b0), .wave(sy));
  eotm_wave #(.DEPTH(SINE_TABLE_DEPTH)) u_cy (
    .clk(clk), .en(en), .angle(angle_y), .cos_sel(1'b1), .wave(cy));
  eotm_wave #(.DEPTH(SINE_TABLE_DEPTH)) u_sz (
    .clk(clk), .en(en), .angle(angle_z), .cos_sel(1'b0), .wave(sz));
  eotm_wave #(.DEPTH(SINE_TABLE_DEPTH)) u_cz (
    .clk(clk), .en(en), .angle(angle_z), .cos_sel(1'b1), .wave(cz));

  // Stage 4: x and y pair products in Q30.
  logic signed [PAIR_W-1:0] p_cc, p_ss, p_sc, p_cs;
  logic signed [TRIG_W-1:0] sz4, cz4;
  always_ff @(posedge clk) begin
    if (en) begin
      p_cc <= PAIR_W'(cx * cy);
      p_ss <= PAIR_W'(sx * sy);
      p_sc <= PAIR_W'(sx * cy);
      p_cs <= PAIR_W'(cx * sy);
      sz4  <= sz;
      cz4  <= cz;
    end
  end

  // Stage 5: quaternion, exact Q45 sums rounded half up to Q30.
  logic signed [48:0] t_w, t_x, t_y, t_z;
  logic signed [QUAT_W-1:0] qw, qx, qy, qz;
  always_comb begin
    t_w = 49'(p_cc * cz4) - 49'(p_ss * sz4);
    t_x = 49'(p_sc * cz4) + 49'(p_cs * sz4);
    t_y = 49'(p_cs * cz4) - 49'(p_sc * sz4);
    t_z = 49'(p_cc * sz4) + 49'(p_ss * cz4);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      qw <= QUAT_W'((t_w + 49'sd16384) >>> 15);
      qx <= QUAT_W'((t_x + 49'sd16384) >>> 15);
      qy <= QUAT_W'((t_y + 49'sd16384) >>> 15);
      qz <= QUAT_W'((t_z + 49'sd16384) >>> 15);
    end
  end

  // Stage 6: quaternion products rounded half up to Q30.
  function automatic logic signed [QUAT_W-1:0] qmul(input logic signed [QUAT_W-1:0] a,
                                                    input logic signed [QUAT_W-1:0] b);
    logic signed [2*QUAT_W-1:0] p;
    p = (2*QUAT_W)'(a) * (2*QUAT_W)'(b);
    p = (p + (2*QUAT_W)'(64'sd1 << 29)) >>> 30;
    return p[QUAT_W-1:0];
  endfunction

  logic signed [QUAT_W-1:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
  always_ff @(posedge clk) begin
    if (en) begin
      xx <= qmul(qx, qx);
      yy <= qmul(qy, qy);
      zz <= qmul(qz, qz);
      xy <= qmul(qx, qy);
      xz <= qmul(qx, qz);
      yz <= qmul(qy, qz);
      xw <= qmul(qx, qw);
      yw <= qmul(qy, qw);
      zw <= qmul(qz, qw);
    end
  end

  // Stage 7: rotation entries, clamped to plus or minus 2^31.
  function automatic logic signed [ROT_W-1:0] rclamp(input logic signed [QUAT_W+1:0] v);
    if (v > (QUAT_W+2)'(64'sd2147483648)) begin
      return ROT_W'(64'sd2147483648);
    end else if (v < -(QUAT_W+2)'(64'sd2147483648)) begin
      return -ROT_W'(64'sd2147483648);
    end
    return v[ROT_W-1:0];
  endfunction

  localparam logic signed [QUAT_W+1:0] ONE_Q30 = (QUAT_W+2)'(64'sd1073741824);

  logic signed [QUAT_W+1:0] r_raw [9];
  always_comb begin
    r_raw[0] = ONE_Q30 - 2 * ((QUAT_W+2)'(yy) + (QUAT_W+2)'(zz));
    r_raw[1] = 2 * ((QUAT_W+2)'(xy) + (QUAT_W+2)'(zw));
    r_raw[2] = 2 * ((QUAT_W+2)'(xz) - (QUAT_W+2)'(yw));
    r_raw[3] = 2 * ((QUAT_W+2)'(xy) - (QUAT_W+2)'(zw));
    r_raw[4] = ONE_Q30 - 2 * ((QUAT_W+2)'(xx) + (QUAT_W+2)'(zz));
    r_raw[5] = 2 * ((QUAT_W+2)'(yz) + (QUAT_W+2)'(xw));
    r_raw[6] = 2 * ((QUAT_W+2)'(xz) + (QUAT_W+2)'(yw));
    r_raw[7] = 2 * ((QUAT_W+2)'(yz) - (QUAT_W+2)'(xw));
    r_raw[8] = ONE_Q30 - 2 * ((QUAT_W+2)'(xx) + (QUAT_W+2)'(yy));
  end

  logic signed [ROT_W-1:0] rm [9];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        rm[i] <= rclamp(r_raw[i]);
      end
    end
  end

  // Stage 8: scale each row.
  localparam int PRW = FIELD_W + ROT_W;
  logic signed [PRW-1:0] sprod [9];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        sprod[i] <= PRW'(scale_d[STAGES-3][i/3]) * PRW'(rm[i]);
      end
    end
  end

  // Stage 9: round half up to Q16.16 and saturate.
  logic signed [PRW-1:0] rnd [9];
  logic signed [FIELD_W-1:0] mat [9];
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rnd[i] = (sprod[i] + PRW'(64'sd536870912)) >>> 30;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        if (rnd[i] > PRW'(64'sd2147483647)) begin
          mat[i] <= 32'sh7fffffff;
        end else if (rnd[i] < -PRW'(64'sd2147483648)) begin
          mat[i] <= 32'sh80000000;
        end else begin
          mat[i] <= rnd[i][FIELD_W-1:0];
        end
      end
    end
  end

  assign m00 = mat[0];
  assign m01 = mat[1];
  assign m02 = mat[2];
  assign m10 = mat[3];
  assign m11 = mat[4];
  assign m12 = mat[5];
  assign m20 = mat[6];
  assign m21 = mat[7];
  assign m22 = mat[8];
  assign m30 = pos_d[STAGES-1][0];
  assign m31 = pos_d[STAGES-1][1];
  assign m32 = pos_d[STAGES-1][2];

endmodule

// ===== hw/rtl/eotm_wave.sv =====
// Three-stage sine or cosine of a half angle through a quarter-wave table.
module eotm_wave import eotm_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [15:0]       angle,
  input  logic                     cos_sel,
  output logic signed [TRIG_W-1:0] wave
);

  localparam int KW = $clog2(DEPTH + 1);
  localparam int NW = $clog2(QUARTER * DEPTH) + 1;
  localparam int MW = NW - 8;
  localparam int PW = MW + 19;

  // Constant quarter-wave table, built at elaboration.
  logic [14:0] sine_rom [DEPTH+1];
  for (genvar g = 0; g <= DEPTH; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, DEPTH);
  end

  // Stage A: reduce the phase to one turn, split into quadrant and remainder.
  logic signed [17:0] ph0;
  logic [15:0]        ph;
  logic [1:0]         quad_a;
  logic [13:0]        rem_a;
  logic [1:0]         quad;
  logic [NW-1:0]      num;

  always_comb begin
    ph0 = 18'(angle) + (cos_sel ? 18'(QUARTER) : 18'sd0);
    if (ph0 < 0) begin
      ph = 16'(ph0 + 18'(TURN));
    end else begin
      ph = 16'(ph0);
    end
    if (ph >= 16'(3 * QUARTER)) begin
      quad_a = 2'd3;
      rem_a  = 14'(ph - 16'(3 * QUARTER));
    end else if (ph >= 16'(2 * QUARTER)) begin
      quad_a = 2'd2;
      rem_a  = 14'(ph - 16'(2 * QUARTER));
    end else if (ph >= 16'(QUARTER)) begin
      quad_a = 2'd1;
      rem_a  = 14'(ph - 16'(QUARTER));
    end else begin
      quad_a = 2'd0;
      rem_a  = 14'(ph);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad <= quad_a;
      num  <= NW'(rem_a) * NW'(DEPTH) + NW'(QUARTER / 2);
    end
  end

  // Stage B: nearest table index by reciprocal multiplication, mirrored per quadrant.
  logic [PW-1:0] kprod;
  logic [KW-1:0] kk;
  logic [KW-1:0] idx;
  logic          neg;

  assign kprod = PW'(num[NW-1:8]) * PW'(RECIP45);
  assign kk    = kprod[RECIP45_SHIFT +: KW];

  always_ff @(posedge clk) begin
    if (en) begin
      idx <= quad[0] ? KW'(DEPTH) - kk : kk;
      neg <= quad[1];
    end
  end

  // Stage C: table read and sign.
  logic signed [TRIG_W-1:0] mag;
  assign mag = $signed({1'b0, sine_rom[idx]});

  always_ff @(posedge clk) begin
    if (en) begin
      wave <= neg ? -mag : mag;
    end
  end

endmodule
